/* rtl/lsup_pkg.sv */
// ----------------------------------------------------------------------------
// Link supervisor package
// Shared widths, codes, payload types and helpers of the telecontrol link
// supervisor.
// ----------------------------------------------------------------------------
package lsup_pkg;

  localparam int SEQ_W      = 15;
  localparam int TMR_W      = 8;
  localparam int CF_W       = 32;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [SEQ_W-1:0] SEQ_MAX = 15'h7fff;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_SFRAME   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TEST_ACT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TEST_CON = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INTERRO  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_T1_OUT   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_T1_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T2_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T3_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WINDOW = 2'd3;

  // Configuration reset values.
  localparam logic [TMR_W-1:0] T1_TIMEOUT_RST = 8'd15;
  localparam logic [TMR_W-1:0] T2_TIMEOUT_RST = 8'd10;
  localparam logic [TMR_W-1:0] T3_TIMEOUT_RST = 8'd20;
  localparam logic [SEQ_W-1:0] ACK_WINDOW_RST = 15'd8;

  // U-frame function codes, octet one bits 7..2.
  localparam logic [5:0] UCODE_STARTDT_CON = 6'b000010;
  localparam logic [5:0] UCODE_TESTFR_ACT  = 6'b010000;
  localparam logic [5:0] UCODE_TESTFR_CON  = 6'b100000;

  // Armed flag bit positions.
  localparam int FLAG_T1 = 0;
  localparam int FLAG_T2 = 1;
  localparam int FLAG_T3 = 2;

  // Queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic            req_type;
    logic [CF_W-1:0] control_field;
  } lsup_in_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SEQ_W-1:0] recv_seq;
    logic [SEQ_W-1:0] send_seq;
    logic             flush;
    logic             last;
  } lsup_out_t;

  // All results of one input item.
  typedef struct packed {
    logic      two;
    lsup_out_t first;
    lsup_out_t second;
  } lsup_entry_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic        valid;
    lsup_entry_t entry;
  } lsup_qhead_t;

  function automatic lsup_out_t make_result(input logic [ACT_W-1:0] action,
                                            input logic [SEQ_W-1:0] rs,
                                            input logic [SEQ_W-1:0] ss,
                                            input logic             flush,
                                            input logic             last);
    lsup_out_t r;
    r.action   = action;
    r.recv_seq = rs;
    r.send_seq = ss;
    r.flush    = flush;
    r.last     = last;
    return r;
  endfunction

endpackage

/* rtl/telecontrol_link_supervisor_top.sv */
// ----------------------------------------------------------------------------
// Telecontrol link supervisor, top level
// Master side of the APCI link control: T1/T2/T3 timers, sequence numbers,
// acknowledgement window, and the control results they trigger.
// ----------------------------------------------------------------------------
// Path: an accepted item's results enter the queue at the accepting edge;
//   the back part then loads the first result into the output register, and
//   a second result of the same item follows it when out_stall is low.
// Throughput: one item per cycle while the queue is not full; the port moves
//   one result per cycle while out_stall is low, so a two-result tick holds it for each of its results.
// Reset: synchronous rst_n clears flags, sequence numbers and queue, reloads
//   the timer counts and restores the configuration defaults.
// ----------------------------------------------------------------------------
module telecontrol_link_supervisor_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lsup_pkg::lsup_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lsup_pkg::lsup_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [lsup_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsup_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsup_pkg::*;

  // The front part decodes each item in the cycle it is accepted and writes
  // its results, one or two, as one entry into the queue; an item with no
  // result writes nothing. It stalls the input only when the queue is full, so
  // it keeps taking items while the output side is held up, until the queue fills.
  logic        push;
  lsup_entry_t push_entry;
  logic        q_full;
  logic        pop;
  lsup_qhead_t q_head;

  lsup_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  // The queue decouples the two parts; each transfer on either side moves
  // independently of the other.
  lsup_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head)
  );

  // The back part unpacks each entry into single result transfers through
  // its output register.
  lsup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/lsup_front.sv */
// ----------------------------------------------------------------------------
// Link supervisor front part
// Accepts ticks and control fields, keeps the timers, sequence numbers and
// configuration, and pushes the results of each item into the queue.
// ----------------------------------------------------------------------------
module lsup_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lsup_pkg::lsup_in_t                 in_data,
  input  logic                               cfg_wr_en,
  input  logic [lsup_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsup_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               q_full,
  output logic                               push,
  output lsup_pkg::lsup_entry_t              push_entry
);
  import lsup_pkg::*;

  logic [TMR_W-1:0] t1_to_r, t2_to_r, t3_to_r;
  logic [SEQ_W-1:0] ack_win_r;

  logic [2:0]       armed_r, armed_nxt;
  logic [TMR_W-1:0] t1_cnt_r, t1_cnt_nxt;
  logic [TMR_W-1:0] t2_cnt_r, t2_cnt_nxt;
  logic [TMR_W-1:0] t3_cnt_r, t3_cnt_nxt;
  logic [SEQ_W-1:0] recv_r, recv_nxt;
  logic [SEQ_W-1:0] send_r, send_nxt;
  logic [SEQ_W-1:0] unack_r, unack_nxt;

  logic             accept;
  logic [TMR_W-1:0] t1_dec, t2_dec, t3_dec;
  logic             fire2, fire3;
  logic [SEQ_W-1:0] nr_field, ns_inc, unack_inc;
  logic [5:0]       ucode;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign t1_dec = (armed_r[FLAG_T1] && t1_cnt_r != '0) ? t1_cnt_r - 1'b1 : t1_cnt_r;
  assign t2_dec = (armed_r[FLAG_T2] && t2_cnt_r != '0) ? t2_cnt_r - 1'b1 : t2_cnt_r;
  assign t3_dec = (armed_r[FLAG_T3] && t3_cnt_r != '0) ? t3_cnt_r - 1'b1 : t3_cnt_r;
  assign fire2  = armed_r[FLAG_T2] && t2_dec == '0;
  assign fire3  = armed_r[FLAG_T3] && t3_dec == '0;

  assign nr_field  = in_data.control_field[31:17];
  assign ns_inc    = in_data.control_field[15:1] + 1'b1;
  assign unack_inc = (unack_r < SEQ_MAX) ? unack_r + 1'b1 : unack_r;
  assign ucode     = in_data.control_field[7:2];

  always_comb begin
    armed_nxt  = armed_r;
    t1_cnt_nxt = t1_cnt_r;
    t2_cnt_nxt = t2_cnt_r;
    t3_cnt_nxt = t3_cnt_r;
    recv_nxt   = recv_r;
    send_nxt   = send_r;
    unack_nxt  = unack_r;
    push       = 1'b0;
    push_entry = '0;
    if (accept) begin
      if (!in_data.req_type) begin
        t1_cnt_nxt = t1_dec;
        t2_cnt_nxt = t2_dec;
        t3_cnt_nxt = t3_dec;
        if (armed_r[FLAG_T1] && t1_dec == '0) begin
          push             = 1'b1;
          push_entry.first = make_result(ACT_T1_OUT, '0, '0, 1'b0, 1'b1);
        end else begin
          if (fire2) begin
            armed_nxt[FLAG_T2] = 1'b0;
            t2_cnt_nxt         = t2_to_r;
            unack_nxt          = '0;
          end
          if (fire3) begin
            armed_nxt[FLAG_T3] = 1'b0;
            t3_cnt_nxt         = t3_to_r;
            armed_nxt[FLAG_T1] = 1'b1;
            t1_cnt_nxt         = t1_to_r;
          end
          push           = fire2 || fire3;
          push_entry.two = fire2 && fire3;
          if (fire2) begin
            push_entry.first = make_result(ACT_SFRAME, recv_r, '0, 1'b0, !fire3);
          end else begin
            push_entry.first = make_result(ACT_TEST_ACT, '0, '0, 1'b0, 1'b1);
          end
          push_entry.second = make_result(ACT_TEST_ACT, '0, '0, 1'b0, 1'b1);
        end
      end else begin
        // Every frame restarts the idle timer; a STARTDT confirm then disarms it.
        armed_nxt[FLAG_T3] = 1'b1;
        t3_cnt_nxt         = t3_to_r;
        if (!in_data.control_field[0]) begin
          if (nr_field == send_r) begin
            armed_nxt[FLAG_T1] = 1'b0;
            t1_cnt_nxt         = t1_to_r;
          end
          armed_nxt[FLAG_T2] = 1'b1;
          t2_cnt_nxt         = t2_to_r;
          recv_nxt           = ns_inc;
          if (unack_inc >= ack_win_r) begin
            armed_nxt[FLAG_T2] = 1'b0;
            unack_nxt          = '0;
            push               = 1'b1;
            push_entry.first   = make_result(ACT_SFRAME, ns_inc, '0, 1'b1, 1'b1);
          end else begin
            unack_nxt = unack_inc;
          end
        end else if (!in_data.control_field[1]) begin
          if (nr_field == send_r) begin
            armed_nxt[FLAG_T1] = 1'b0;
            t1_cnt_nxt         = t1_to_r;
          end
        end else begin
          priority if (ucode == UCODE_STARTDT_CON) begin
            armed_nxt        = '0;
            t1_cnt_nxt       = t1_to_r;
            t2_cnt_nxt       = t2_to_r;
            t3_cnt_nxt       = t3_to_r;
            unack_nxt        = '0;
            recv_nxt         = '0;
            send_nxt         = SEQ_W'(1);
            push             = 1'b1;
            push_entry.first = make_result(ACT_INTERRO, '0, '0, 1'b0, 1'b1);
          end else if (ucode == UCODE_TESTFR_CON) begin
            armed_nxt[FLAG_T1] = 1'b0;
            t1_cnt_nxt         = t1_to_r;
          end else if (ucode == UCODE_TESTFR_ACT) begin
            push             = 1'b1;
            push_entry.first = make_result(ACT_TEST_CON, '0, '0, 1'b0, 1'b1);
          end else begin
            push = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_to_r   <= T1_TIMEOUT_RST;
      t2_to_r   <= T2_TIMEOUT_RST;
      t3_to_r   <= T3_TIMEOUT_RST;
      ack_win_r <= ACK_WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_T1_TIMEOUT: t1_to_r   <= cfg_data[TMR_W-1:0];
        CFG_T2_TIMEOUT: t2_to_r   <= cfg_data[TMR_W-1:0];
        CFG_T3_TIMEOUT: t3_to_r   <= cfg_data[TMR_W-1:0];
        CFG_ACK_WINDOW: ack_win_r <= cfg_data[SEQ_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= '0;
      t1_cnt_r <= T1_TIMEOUT_RST;
      t2_cnt_r <= T2_TIMEOUT_RST;
      t3_cnt_r <= T3_TIMEOUT_RST;
      recv_r   <= '0;
      send_r   <= '0;
      unack_r  <= '0;
    end else begin
      armed_r  <= armed_nxt;
      t1_cnt_r <= t1_cnt_nxt;
      t2_cnt_r <= t2_cnt_nxt;
      t3_cnt_r <= t3_cnt_nxt;
      recv_r   <= recv_nxt;
      send_r   <= send_nxt;
      unack_r  <= unack_nxt;
    end
  end

  // A push only ever comes from an accepted item.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_valid && !q_full))
    else $error("front pushed without an accepted item");

  // The last flag sits on the final result of every pushed entry.
  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.two ? (push_entry.second.last && !push_entry.first.last)
                             : push_entry.first.last))
    else $error("pushed entry has a misplaced last flag");

  // Only a tick can cause two results.
  a_two_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.two) |-> !in_data.req_type)
    else $error("a frame pushed a two-result entry");

endmodule

/* rtl/lsup_queue.sv */
// ----------------------------------------------------------------------------
// Link supervisor queue
// Short queue of per-item result entries between the front and back parts.
// ----------------------------------------------------------------------------
module lsup_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lsup_pkg::lsup_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output lsup_pkg::lsup_qhead_t head
);
  import lsup_pkg::*;

  lsup_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == QCNT_W'(QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head.valid))
    else $error("pop from an empty queue");

endmodule

/* rtl/lsup_back.sv */
// ----------------------------------------------------------------------------
// Link supervisor back part
// Takes entries from the queue and presents their results one per transfer
// from an output register.
// ----------------------------------------------------------------------------
module lsup_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsup_pkg::lsup_qhead_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsup_pkg::lsup_out_t   out_data
);
  import lsup_pkg::*;

  logic      out_valid_r;
  lsup_out_t out_r;
  logic      pend_r;
  lsup_out_t pend_res_r;
  logic      load;

  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && !pend_r && head.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_r <= pend_res_r;
      end else if (head.valid) begin
        out_r      <= head.entry.first;
        pend_res_r <= head.entry.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= head.valid;
        pend_r      <= head.valid && head.entry.two;
      end
    end
  end

  // A second result only waits behind a first one on the port.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second result pending with empty output register");

  // No new entry is taken while a second result is still owed.
  a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !pop)
    else $error("queue popped while a second result is pending");

  // Popping a two-result entry leaves its second result pending.
  a_two_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.entry.two) |=> pend_r)
    else $error("second result of an entry was dropped");

endmodule

/* tb/lsup_link_checker.sv */
// ----------------------------------------------------------------------------
// Link supervisor result checker
// Watches the item, result and register ports of the link supervisor, keeps
// its own copy of the timers, sequence numbers and settings, predicts the
// results of every accepted item and compares each result transfer against
// the oldest prediction.
// ----------------------------------------------------------------------------
module lsup_link_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  lsup_pkg::lsup_in_t                 in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  lsup_pkg::lsup_out_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [lsup_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsup_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int unsigned                        fail_count,
  output int unsigned                        open_results
);

  timeunit 1ns;
  timeprecision 1ps;

  import lsup_pkg::*;

  // Settings as last written.
  logic [TMR_W-1:0] t1_reload, t2_reload, t3_reload;
  logic [SEQ_W-1:0] ack_limit;

  // Link state.
  logic [2:0]       armed;
  logic [TMR_W-1:0] t1_cnt, t2_cnt, t3_cnt;
  logic [SEQ_W-1:0] recv_num, send_num, unacked;

  lsup_out_t   awaited[$];
  int unsigned fails = 0;

  function automatic lsup_out_t result_of(input logic [ACT_W-1:0] action,
                                          input logic [SEQ_W-1:0] rs,
                                          input logic [SEQ_W-1:0] ss,
                                          input logic             flush);
    lsup_out_t r;
    r.action   = action;
    r.recv_seq = rs;
    r.send_seq = ss;
    r.flush    = flush;
    r.last     = 1'b0;
    return r;
  endfunction

  // Arms or disarms one timer; either way its count is reloaded.
  task automatic set_timer(input int which, input logic on);
    armed[which] = on;
    case (which)
      FLAG_T1: t1_cnt = t1_reload;
      FLAG_T2: t2_cnt = t2_reload;
      default: t3_cnt = t3_reload;
    endcase
  endtask

  task automatic advance_link(input lsup_in_t item);
    lsup_out_t        produced[2];
    int               n;
    logic [CF_W-1:0]  cf;
    logic [SEQ_W-1:0] nr;
    n  = 0;
    cf = item.control_field;
    nr = cf[31:17];
    if (!item.req_type) begin
      if (armed[FLAG_T1] && t1_cnt != 0) t1_cnt = t1_cnt - 1'b1;
      if (armed[FLAG_T2] && t2_cnt != 0) t2_cnt = t2_cnt - 1'b1;
      if (armed[FLAG_T3] && t3_cnt != 0) t3_cnt = t3_cnt - 1'b1;
      if (armed[FLAG_T1] && t1_cnt == 0) begin
        // An expired T1 blocks everything else and repeats on each tick.
        produced[n] = result_of(ACT_T1_OUT, '0, '0, 1'b0);
        n++;
      end else begin
        if (armed[FLAG_T2] && t2_cnt == 0) begin
          produced[n] = result_of(ACT_SFRAME, recv_num, '0, 1'b0);
          n++;
          set_timer(FLAG_T2, 1'b0);
          unacked = '0;
        end
        if (armed[FLAG_T3] && t3_cnt == 0) begin
          produced[n] = result_of(ACT_TEST_ACT, '0, '0, 1'b0);
          n++;
          set_timer(FLAG_T3, 1'b0);
          set_timer(FLAG_T1, 1'b1);
        end
      end
    end else begin
      set_timer(FLAG_T3, 1'b1);
      if (!cf[0]) begin
        recv_num = cf[15:1];
        if (nr == send_num) set_timer(FLAG_T1, 1'b0);
        set_timer(FLAG_T2, 1'b1);
        if (unacked != SEQ_MAX) unacked = unacked + 1'b1;
        recv_num = (recv_num == SEQ_MAX) ? '0 : recv_num + 1'b1;
        if (unacked >= ack_limit) begin
          produced[n] = result_of(ACT_SFRAME, recv_num, '0, 1'b1);
          n++;
          set_timer(FLAG_T2, 1'b0);
          unacked = '0;
        end
      end else if (!cf[1]) begin
        if (nr == send_num) set_timer(FLAG_T1, 1'b0);
      end else begin
        case (cf[7:2])
          UCODE_STARTDT_CON: begin
            armed    = '0;
            t1_cnt   = t1_reload;
            t2_cnt   = t2_reload;
            t3_cnt   = t3_reload;
            unacked  = '0;
            recv_num = '0;
            send_num = '0;
            produced[n] = result_of(ACT_INTERRO, recv_num, send_num, 1'b0);
            n++;
            send_num = send_num + 1'b1;
          end
          UCODE_TESTFR_CON: set_timer(FLAG_T1, 1'b0);
          UCODE_TESTFR_ACT: begin
            produced[n] = result_of(ACT_TEST_CON, '0, '0, 1'b0);
            n++;
          end
          default: ;
        endcase
      end
    end
    if (n > 0) produced[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited.push_back(produced[i]);
  endtask

  task automatic note_field(input string name, input logic [SEQ_W-1:0] want_v,
                            input logic [SEQ_W-1:0] got_v);
    fails++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
  endtask

  task automatic check_result(input lsup_out_t got);
    lsup_out_t want;
    if (awaited.size() == 0) begin
      fails++;
      $display("%0t: expected no result, got action %0d recv %0d send %0d",
               $time, got.action, got.recv_seq, got.send_seq);
    end else begin
      want = awaited.pop_front();
      if (got.action !== want.action)
        note_field("action", SEQ_W'(want.action), SEQ_W'(got.action));
      if (got.recv_seq !== want.recv_seq)
        note_field("recv_seq", want.recv_seq, got.recv_seq);
      if (got.send_seq !== want.send_seq)
        note_field("send_seq", want.send_seq, got.send_seq);
      if (got.flush !== want.flush)
        note_field("flush", SEQ_W'(want.flush), SEQ_W'(got.flush));
      if (got.last !== want.last)
        note_field("last", SEQ_W'(want.last), SEQ_W'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      t1_reload = T1_TIMEOUT_RST;
      t2_reload = T2_TIMEOUT_RST;
      t3_reload = T3_TIMEOUT_RST;
      ack_limit = ACK_WINDOW_RST;
      armed     = '0;
      t1_cnt    = T1_TIMEOUT_RST;
      t2_cnt    = T2_TIMEOUT_RST;
      t3_cnt    = T3_TIMEOUT_RST;
      recv_num  = '0;
      send_num  = '0;
      unacked   = '0;
      awaited.delete();
    end else begin
      // Results leave only after their item has passed the queue and the output
      // register, so the compare goes before the prediction of an item taken at the same edge.
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_T1_TIMEOUT: t1_reload = cfg_data[TMR_W-1:0];
          CFG_T2_TIMEOUT: t2_reload = cfg_data[TMR_W-1:0];
          CFG_T3_TIMEOUT: t3_reload = cfg_data[TMR_W-1:0];
          CFG_ACK_WINDOW: ack_limit = cfg_data[SEQ_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_link(in_data);
    end
    fail_count   <= fails;
    open_results <= awaited.size();
  end

endmodule

/* tb/tb_telecontrol_link_supervisor_top.sv */
// ----------------------------------------------------------------------------
// Telecontrol link supervisor testbench
// Drives ticks and received control fields into the link supervisor under
// several timer and window settings, with random gaps on the item side and
// random stalls on the result side. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_telecontrol_link_supervisor_top;

  timeunit 1ns;
  timeprecision 1ps;

  import lsup_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WAIT     = 16;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int LIMIT_NS     = 2_000_000;

  // Item kinds.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // Frame format bits in octet one.
  localparam logic [1:0] FMT_S = 2'b01;
  localparam logic [1:0] FMT_U = 2'b11;

  // U-frame codes that the block only treats as activity.
  localparam logic [5:0] UCODE_STARTDT_ACT = 6'b000001;
  localparam logic [5:0] UCODE_STOPDT_ACT  = 6'b000100;
  localparam logic [5:0] UCODE_STOPDT_CON  = 6'b001000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  lsup_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lsup_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned open_results;

  // When set, the matching side runs without any idle cycles for a phase.
  logic quiet_in  = 1'b0;
  logic quiet_out = 1'b0;

  // Result-side stall countdown and the draw that feeds it.
  int unsigned stall_left = 0;
  int unsigned stall_draw;

  // What a well-behaved peer would send next: its own send number, and the
  // send number it believes the block is at.
  logic [SEQ_W-1:0] stream_ns = '0;
  logic [SEQ_W-1:0] peer_send = '0;

  telecontrol_link_supervisor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lsup_link_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always #1 clk = ~clk;

  // After every result transfer the receiver draws how many cycles it holds
  // off the next one. Stall is raised and lowered only at the rising edge, so
  // a stalled result always sees a steady stall between edges.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = quiet_out ? 0 : $urandom_range(0, MAX_WAIT);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog: a lost result or a stuck handshake ends the run here.
  initial begin
    #(LIMIT_NS);
    $display("telecontrol_link_supervisor_top: mismatch");
    $finish;
  end

  function automatic logic [SEQ_W-1:0] any_seq();
    logic [31:0] r;
    r = $urandom;
    return r[SEQ_W-1:0];
  endfunction

  // Tick items carry a random control field, which the block must ignore.
  function automatic lsup_in_t tick_of();
    lsup_in_t item;
    item.req_type      = REQ_TICK;
    item.control_field = $urandom;
    return item;
  endfunction

  function automatic lsup_in_t frame_of(input logic [CF_W-1:0] cf);
    lsup_in_t item;
    item.req_type      = REQ_FRAME;
    item.control_field = cf;
    return item;
  endfunction

  // I-frame: send number in octets one and two, receive number in three and
  // four; the spare bit under the receive number is random.
  function automatic logic [CF_W-1:0] iframe_cf(input logic [SEQ_W-1:0] ns,
                                                input logic [SEQ_W-1:0] nr);
    logic [31:0] r;
    r = $urandom;
    return {nr, r[0], ns, 1'b0};
  endfunction

  function automatic logic [CF_W-1:0] sframe_cf(input logic [SEQ_W-1:0] nr);
    logic [31:0] r;
    r = $urandom;
    return {nr, r[16], r[13:0], FMT_S};
  endfunction

  // U-frame; with noisy set the three upper octets carry random bits.
  function automatic logic [CF_W-1:0] uframe_cf(input logic [5:0] code,
                                                input logic       noisy);
    logic [31:0] r;
    r = noisy ? $urandom : 32'd0;
    return {r[23:0], code, FMT_U};
  endfunction

  // Mostly acknowledge what the block has sent, so that T1 gets released.
  function automatic logic [SEQ_W-1:0] ack_nr();
    return ($urandom_range(0, 9) < 7) ? peer_send : any_seq();
  endfunction

  // Mostly a well-formed conversation: ticks, in-order I-frames, S-frames
  // and U-frames a peer would send, with a share of broken fields and noise.
  function automatic lsup_in_t random_link_item();
    int unsigned     pick;
    logic [CF_W-1:0] cf;
    logic [5:0]      code;
    pick = $urandom_range(0, 99);
    if (pick < 40) return tick_of();
    if (pick < 66) begin
      if ($urandom_range(0, 9) == 0) stream_ns = any_seq();
      cf        = iframe_cf(stream_ns, ack_nr());
      stream_ns = stream_ns + 1'b1;
    end else if (pick < 76) begin
      cf = sframe_cf(ack_nr());
    end else if (pick < 95) begin
      case ($urandom_range(0, 19))
        0: begin
          code      = UCODE_STARTDT_CON;
          stream_ns = '0;
          peer_send = SEQ_W'(1);
        end
        1, 2, 3, 4, 5, 6, 7: code = UCODE_TESTFR_CON;
        8, 9, 10, 11, 12:    code = UCODE_TESTFR_ACT;
        13:                  code = UCODE_STARTDT_ACT;
        14:                  code = UCODE_STOPDT_ACT;
        15:                  code = UCODE_STOPDT_CON;
        default:             code = 6'($urandom_range(0, 63));
      endcase
      cf = uframe_cf(code, $urandom_range(0, 3) == 0);
    end else begin
      cf = $urandom;
    end
    return frame_of(cf);
  endfunction

  // Presents one item after a random gap and returns in the time step of the
  // edge that accepts it. Valid stays high into the next item when no gap is
  // drawn. Stall is looked at on the falling edge, where it is steady.
  task automatic send_item(input lsup_in_t item);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Stops sending and waits for every predicted result, then lets the block
  // finish items that cause no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] t1,
                                input logic [CFG_DATA_W-1:0] t2,
                                input logic [CFG_DATA_W-1:0] t3,
                                input logic [CFG_DATA_W-1:0] window);
    write_reg(CFG_T1_TIMEOUT, t1);
    write_reg(CFG_T2_TIMEOUT, t2);
    write_reg(CFG_T3_TIMEOUT, t3);
    write_reg(CFG_ACK_WINDOW, window);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Short timers, with T2 and T3 equal so that one tick can
    // expire both, and a window of three I-frames.
    write_settings(2, 4, 4, 3);

    // A tick with nothing armed, then an S-frame that acknowledges send
    // number zero.
    send_item(tick_of());
    send_item(frame_of(sframe_cf('0)));
    // STARTDT confirm gives the interrogation; a test activation is answered.
    send_item(frame_of(uframe_cf(UCODE_STARTDT_CON, 1'b0)));
    peer_send = SEQ_W'(1);
    send_item(frame_of(uframe_cf(UCODE_TESTFR_ACT, 1'b1)));
    // The receive number wraps from its top value to zero; the third I-frame
    // fills the window and forces a flushed S-frame.
    send_item(frame_of(iframe_cf(SEQ_MAX, peer_send)));
    send_item(frame_of(iframe_cf(15'd5, SEQ_MAX)));
    send_item(frame_of(iframe_cf(15'd6, peer_send)));
    // T3 runs out: test activation, which arms T1.
    repeat (4) send_item(tick_of());
    // T1 runs out and keeps reporting on every tick until a test confirm.
    repeat (3) send_item(tick_of());
    send_item(frame_of(uframe_cf(UCODE_TESTFR_CON, 1'b0)));
    // An unacknowledging I-frame arms T2 and T3 together; both expire on the
    // same tick and that tick has two results.
    send_item(frame_of(iframe_cf(15'd7, '0)));
    repeat (4) send_item(tick_of());
    // Release T1 by an S-frame, then frames that only count as activity.
    send_item(frame_of(sframe_cf(peer_send)));
    send_item(frame_of(uframe_cf(UCODE_STARTDT_ACT, 1'b0)));
    send_item(frame_of(uframe_cf(UCODE_STOPDT_ACT, 1'b0)));
    send_item(frame_of(uframe_cf(UCODE_STOPDT_CON, 1'b0)));
    send_item(frame_of('1));
    send_item(frame_of('0));
    stream_ns = SEQ_W'(1);

    // Random part, one setting per phase: all registers at zero, at their
    // maxima, at one, back at their reset values, then random settings that
    // are mostly short so that the timers do expire.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_settings(0, 0, 0, 0);
        1: write_settings(CFG_DATA_W'(255), CFG_DATA_W'(255), CFG_DATA_W'(255),
                          SEQ_MAX);
        2: write_settings(1, 1, 1, 1);
        3: write_settings(CFG_DATA_W'(T1_TIMEOUT_RST), CFG_DATA_W'(T2_TIMEOUT_RST),
                          CFG_DATA_W'(T3_TIMEOUT_RST), ACK_WINDOW_RST);
        default: begin
          if ($urandom_range(0, 4) == 0)
            write_settings(CFG_DATA_W'($urandom_range(1, 255)),
                           CFG_DATA_W'($urandom_range(1, 255)),
                           CFG_DATA_W'($urandom_range(1, 255)),
                           CFG_DATA_W'($urandom_range(1, SEQ_MAX)));
          else
            write_settings(CFG_DATA_W'($urandom_range(1, 10)),
                           CFG_DATA_W'($urandom_range(1, 10)),
                           CFG_DATA_W'($urandom_range(1, 10)),
                           CFG_DATA_W'($urandom_range(1, 12)));
        end
      endcase
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through each phase the sender holds off until the result
        // side has caught up completely.
        if (k == PHASE_ITEMS / 2) wait_idle();
        send_item(random_link_item());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("telecontrol_link_supervisor_top: match");
    end else begin
      $display("telecontrol_link_supervisor_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lsup_pkg.sv
rtl/lsup_front.sv
rtl/lsup_queue.sv
rtl/lsup_back.sv
rtl/telecontrol_link_supervisor_top.sv
tb/lsup_link_checker.sv
tb/tb_telecontrol_link_supervisor_top.sv
